// ===== rtl/core/extent_node_parser_assert.svh =====
// Assertion macros for the extent node parser.
`ifndef EXTENT_NODE_PARSER_ASSERT_SVH
`define EXTENT_NODE_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define ENP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define ENP_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define ENP_ASSERT(lbl, prop, msg)
`define ENP_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/enp_pkg.sv =====
package enp_pkg;

   localparam logic [16:0] MAX_NODE_BYTES = 17'd65536;
   localparam logic [16:0] POS_MAX        = 17'h1FFFF;
   localparam logic [15:0] NODE_MAGIC     = 16'hF30A;
   localparam logic [15:0] UNWRITTEN_BASE = 16'd32768;
   localparam logic [15:0] MAX_DEPTH_RST  = 16'd5;
   localparam logic [3:0]  LAST_IDX       = 4'd11;
   localparam logic [16:0] HDR_BYTES      = 17'd12;

   localparam logic [1:0] MODE_HDR   = 2'd0;
   localparam logic [1:0] MODE_LEAF  = 2'd1;
   localparam logic [1:0] MODE_INDEX = 2'd2;
   localparam logic [1:0] MODE_RSVD  = 2'd3;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_LEAF   = 2'd1;
   localparam logic [1:0] KIND_INDEX  = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED = 3'd1;
   localparam logic [2:0] ERR_MAGIC     = 3'd2;
   localparam logic [2:0] ERR_DEPTH     = 3'd3;
   localparam logic [2:0] ERR_ENTRIES   = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  error_code;
      logic        last;
      logic [95:0] data;
   } enp_rec_type;

endpackage

// ===== rtl/core/enp_front.sv =====
module enp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic [1:0]         req_func,
   input  logic [16:0]        req_node_bytes,
   input  logic               req_last_byte,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   input  logic               q_full,
   output logic               q_push,
   output enp_pkg::enp_rec_type q_rec
);
   import enp_pkg::*;

   logic [16:0] pos_ff, pos_in;
   logic [3:0]  idx_ff, idx_in;
   logic [1:0]  mode_ff, mode_in;
   logic [16:0] size_ff, size_in;
   logic [15:0] ents_ff, ents_in;
   logic [15:0] done_ff, done_in;
   logic        fin_ff, fin_in;
   logic [15:0] max_depth_ff;
   logic [7:0]  ent_ff [12];

   logic        accept, first, fin_cur;
   logic [15:0] ents_cur, done_cur, done_plus;
   logic [7:0]  cur [12];
   logic [95:0] cur_vec;
   logic [15:0] magic, cnt, dep;
   logic [19:0] need;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign first     = (pos_ff == '0);
   assign fin_cur   = first ? 1'b0 : fin_ff;
   assign ents_cur  = first ? '0 : ents_ff;
   assign done_cur  = first ? '0 : done_ff;
   assign done_plus = done_cur + 16'd1;

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         cur[i] = (idx_ff == 4'(i)) ? req_data_byte : ent_ff[i];
         cur_vec[8*i +: 8] = cur[i];
      end
   end

   assign magic = {cur[1], cur[0]};
   assign cnt   = {cur[3], cur[2]};
   assign dep   = {cur[7], cur[6]};
   assign need  = 20'd12 + {1'b0, cnt, 3'b000} + {2'b00, cnt, 2'b00};

   always_comb begin
      pos_in  = pos_ff;
      idx_in  = idx_ff;
      mode_in = mode_ff;
      size_in = size_ff;
      ents_in = ents_ff;
      done_in = done_ff;
      fin_in  = fin_ff;
      q_push  = 1'b0;
      q_rec.kind       = KIND_ERROR;
      q_rec.error_code = ERR_NONE;
      q_rec.last       = 1'b1;
      q_rec.data       = cur_vec;
      if (accept) begin
         if (first) begin
            mode_in = (req_func == MODE_RSVD) ? MODE_HDR : req_func;
            size_in = (req_node_bytes > MAX_NODE_BYTES) ? MAX_NODE_BYTES : req_node_bytes;
         end
         ents_in = ents_cur;
         done_in = done_cur;
         fin_in  = fin_cur;
         if (!fin_cur && idx_ff == LAST_IDX) begin
            q_push = 1'b1;
            if (pos_ff < HDR_BYTES) begin
               fin_in = 1'b1;
               if (magic != NODE_MAGIC) begin
                  q_rec.error_code = ERR_MAGIC;
               end else if (dep > max_depth_ff) begin
                  q_rec.error_code = ERR_DEPTH;
               end else if (need > {3'b000, size_in}) begin
                  q_rec.error_code = ERR_ENTRIES;
               end else if ((mode_in == MODE_LEAF && dep != '0) ||
                            (mode_in == MODE_INDEX && dep == '0)) begin
                  q_rec.error_code = ERR_DEPTH;
               end else begin
                  q_rec.kind = KIND_HEADER;
                  ents_in    = cnt;
                  if (mode_in != MODE_HDR && cnt != '0) fin_in = 1'b0;
                  q_rec.last = fin_in;
               end
            end else begin
               q_rec.kind = (mode_in == MODE_LEAF) ? KIND_LEAF : KIND_INDEX;
               done_in    = done_plus;
               if (done_plus >= ents_cur) fin_in = 1'b1;
               q_rec.last = fin_in;
            end
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 17'd1;
            idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 4'd1;
         end
         if (req_last_byte) begin
            if (!fin_in) begin
               q_push           = 1'b1;
               q_rec.kind       = KIND_ERROR;
               q_rec.error_code = ERR_TRUNCATED;
               q_rec.last       = 1'b1;
               fin_in           = 1'b1;
            end
            pos_in = '0;
            idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         idx_ff       <= '0;
         mode_ff      <= MODE_HDR;
         size_ff      <= '0;
         ents_ff      <= '0;
         done_ff      <= '0;
         fin_ff       <= 1'b0;
         max_depth_ff <= MAX_DEPTH_RST;
      end else begin
         pos_ff  <= pos_in;
         idx_ff  <= idx_in;
         mode_ff <= mode_in;
         size_ff <= size_in;
         ents_ff <= ents_in;
         done_ff <= done_in;
         fin_ff  <= fin_in;
         if (csr_write_enable) max_depth_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !fin_cur) ent_ff[idx_ff] <= req_data_byte;
   end

endmodule

// ===== rtl/core/enp_queue.sv =====
module enp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  enp_pkg::enp_rec_type push_rec,
   output logic                 full,
   input  logic                 pop,
   output logic                 q_valid,
   output enp_pkg::enp_rec_type q_rec
);
   import enp_pkg::*;

   `include "extent_node_parser_assert.svh"

   enp_rec_type mem_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  count_ff;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_rec   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_rec;
   end

   `ENP_NEVER(a_no_overflow, push && full, "transaction pushed into full queue")
   `ENP_NEVER(a_no_underflow, pop && !q_valid, "pop from empty queue")
   `ENP_NEVER(a_count_range, count_ff == 2'd3, "queue count out of range")
   `ENP_ASSERT(a_ptr_gap, (count_ff == 2'd1) == (wr_ff != rd_ff), "queue pointers disagree")

endmodule

// ===== rtl/core/enp_back.sv =====
module enp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  enp_pkg::enp_rec_type q_rec,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [2:0]           rsp_error_code,
   output logic [15:0]          rsp_entry_count,
   output logic [15:0]          rsp_entry_capacity,
   output logic [15:0]          rsp_tree_depth,
   output logic [31:0]          rsp_file_block,
   output logic [15:0]          rsp_block_count,
   output logic [47:0]          rsp_device_block,
   output logic                 rsp_written,
   output logic                 rsp_last_result
);
   import enp_pkg::*;

   logic        valid_ff;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  err_ff, err_in;
   logic [15:0] cnt_ff, cnt_in, cap_ff, cap_in, dep_ff, dep_in;
   logic [31:0] fblk_ff, fblk_in;
   logic [15:0] bcnt_ff, bcnt_in;
   logic [47:0] dblk_ff, dblk_in;
   logic        wr_ff, wr_in;
   logic        last_ff;
   logic [95:0] d;
   logic [15:0] len;
   logic        init;

   assign pop  = q_valid && (!valid_ff || rsp_ready);
   assign d    = q_rec.data;
   assign len  = d[47:32];
   assign init = (len <= UNWRITTEN_BASE);

   always_comb begin
      kind_in = q_rec.kind;
      err_in  = ERR_NONE;
      cnt_in  = '0;
      cap_in  = '0;
      dep_in  = '0;
      fblk_in = '0;
      bcnt_in = '0;
      dblk_in = '0;
      wr_in   = 1'b0;
      unique case (q_rec.kind)
         KIND_HEADER: begin
            cnt_in = d[31:16];
            cap_in = d[47:32];
            dep_in = d[63:48];
         end
         KIND_LEAF: begin
            fblk_in = d[31:0];
            bcnt_in = init ? len : len - UNWRITTEN_BASE;
            dblk_in = {d[63:48], d[95:64]};
            wr_in   = init;
         end
         KIND_INDEX: begin
            fblk_in = d[31:0];
            dblk_in = {d[79:64], d[63:32]};
         end
         default: begin
            err_in = q_rec.error_code;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= kind_in;
         err_ff  <= err_in;
         cnt_ff  <= cnt_in;
         cap_ff  <= cap_in;
         dep_ff  <= dep_in;
         fblk_ff <= fblk_in;
         bcnt_ff <= bcnt_in;
         dblk_ff <= dblk_in;
         wr_ff   <= wr_in;
         last_ff <= q_rec.last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_entry_count    = cnt_ff;
   assign rsp_entry_capacity = cap_ff;
   assign rsp_tree_depth     = dep_ff;
   assign rsp_file_block     = fblk_ff;
   assign rsp_block_count    = bcnt_ff;
   assign rsp_device_block   = dblk_ff;
   assign rsp_written        = wr_ff;
   assign rsp_last_result    = last_ff;

endmodule

// ===== rtl/core/extent_node_parser.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   data_byte, func, node_bytes, last_byte
// rsp       out        rsp_valid/rsp_ready   header, extent, index or error fields
// csr       in         csr_write_enable      max_depth (16 bits)
//
// One byte transaction per cycle. The byte that completes a result writes the
// queue at its accepting edge; rsp_valid rises once the output register loads it.
// Throughput is set by the front byte loop: one byte per cycle while the
// two-entry queue has room.
// Synchronous active-high reset; no clearing pass, max_depth resets to 5.
// A stalled rsp side back-pressures req only once the queue is full.
module extent_node_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic [1:0]  req_func,
   input  logic [16:0] req_node_bytes,
   input  logic        req_last_byte,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_error_code,
   output logic [15:0] rsp_entry_count,
   output logic [15:0] rsp_entry_capacity,
   output logic [15:0] rsp_tree_depth,
   output logic [31:0] rsp_file_block,
   output logic [15:0] rsp_block_count,
   output logic [47:0] rsp_device_block,
   output logic        rsp_written,
   output logic        rsp_last_result
);
   import enp_pkg::*;

   logic        q_full, q_push, q_pop, q_valid;
   enp_rec_type push_rec, pop_rec;

   enp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_func         (req_func),
      .req_node_bytes   (req_node_bytes),
      .req_last_byte    (req_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_rec            (push_rec)
   );

   enp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (push_rec),
      .full     (q_full),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_rec    (pop_rec)
   );

   enp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_rec              (pop_rec),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_error_code     (rsp_error_code),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_entry_capacity (rsp_entry_capacity),
      .rsp_tree_depth     (rsp_tree_depth),
      .rsp_file_block     (rsp_file_block),
      .rsp_block_count    (rsp_block_count),
      .rsp_device_block   (rsp_device_block),
      .rsp_written        (rsp_written),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import enp_pkg::*;

   typedef struct {
      logic [7:0]  data_byte;
      logic [1:0]  func;
      logic [16:0] node_bytes;
      logic        last_byte;
   } byte_txn_type;

   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  error_code;
      logic [15:0] entry_count;
      logic [15:0] entry_capacity;
      logic [15:0] tree_depth;
      logic [31:0] file_block;
      logic [15:0] block_count;
      logic [47:0] device_block;
      logic        written;
      logic        last_result;
   } node_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic [1:0]  req_func = '0;
   logic [16:0] req_node_bytes = '0;
   logic        req_last_byte = 1'b0;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_error_code;
   logic [15:0] rsp_entry_count;
   logic [15:0] rsp_entry_capacity;
   logic [15:0] rsp_tree_depth;
   logic [31:0] rsp_file_block;
   logic [15:0] rsp_block_count;
   logic [47:0] rsp_device_block;
   logic        rsp_written;
   logic        rsp_last_result;

   byte_txn_type    pending_bytes[$];
   node_result_type expected_results[$];
   int unsigned  fail_count = 0;
   int unsigned  send_idle = 19;
   int unsigned  recv_idle = 52;
   int unsigned  stall_left = 0;

   // predictor state
   logic [15:0] depth_limit = MAX_DEPTH_RST;
   logic [16:0] pos_q;
   logic [1:0]  mode_q;
   logic [16:0] size_q;
   logic [15:0] hdr_entries_q;
   logic [15:0] entries_seen_q;
   logic [7:0]  ent_buf[12];
   logic        finished_q;

   extent_node_parser uut (.*);

   always #5 clock = ~clock;

   function automatic logic [15:0] buf16(int at);
      return {ent_buf[at + 1], ent_buf[at]};
   endfunction

   function automatic logic [31:0] buf32(int at);
      return {buf16(at + 2), buf16(at)};
   endfunction

   function automatic node_result_type error_result(logic [2:0] code);
      node_result_type r;
      r = '{default: '0};
      r.kind = KIND_ERROR;
      r.error_code = code;
      r.last_result = 1'b1;
      return r;
   endfunction

   task automatic parse_byte(input byte_txn_type t, output bit got,
                             output node_result_type r);
      int idx;
      logic [15:0] magic, cnt, cap, dep, len;
      got = 0;
      r = '{default: '0};
      if (pos_q == 0) begin
         mode_q = (t.func == MODE_RSVD) ? MODE_HDR : t.func;
         size_q = (t.node_bytes > MAX_NODE_BYTES) ? MAX_NODE_BYTES : t.node_bytes;
         hdr_entries_q = '0;
         entries_seen_q = '0;
         finished_q = 1'b0;
      end
      if (!finished_q) begin
         idx = (pos_q < HDR_BYTES) ? int'(pos_q) : int'((pos_q - HDR_BYTES) % 12);
         ent_buf[idx] = t.data_byte;
         if (idx == 11) begin
            got = 1;
            if (pos_q < HDR_BYTES) begin
               magic = buf16(0); cnt = buf16(2); cap = buf16(4); dep = buf16(6);
               finished_q = 1'b1;
               if (magic != NODE_MAGIC) r = error_result(ERR_MAGIC);
               else if (dep > depth_limit) r = error_result(ERR_DEPTH);
               else if (32'd12 + 32'(cnt) * 32'd12 > 32'(size_q)) r = error_result(ERR_ENTRIES);
               else if (mode_q == MODE_LEAF && dep != 0) r = error_result(ERR_DEPTH);
               else if (mode_q == MODE_INDEX && dep == 0) r = error_result(ERR_DEPTH);
               else begin
                  hdr_entries_q = cnt;
                  r.kind = KIND_HEADER;
                  r.entry_count = cnt;
                  r.entry_capacity = cap;
                  r.tree_depth = dep;
                  if (mode_q != MODE_HDR && cnt != 0) finished_q = 1'b0;
                  r.last_result = finished_q;
               end
            end else begin
               r.file_block = buf32(0);
               if (mode_q == MODE_LEAF) begin
                  len = buf16(4);
                  r.kind = KIND_LEAF;
                  r.written = (len <= UNWRITTEN_BASE);
                  r.block_count = r.written ? len : len - UNWRITTEN_BASE;
                  r.device_block = {buf16(6), buf32(8)};
               end else begin
                  r.kind = KIND_INDEX;
                  r.device_block = {buf16(8), buf32(4)};
               end
               entries_seen_q = entries_seen_q + 1'b1;
               if (entries_seen_q >= hdr_entries_q) finished_q = 1'b1;
               r.last_result = finished_q;
            end
         end
      end
      if (pos_q < POS_MAX) pos_q = pos_q + 1'b1;
      if (t.last_byte) begin
         if (!finished_q) begin
            r = error_result(ERR_TRUNCATED);
            finished_q = 1'b1;
            got = 1;
         end
         pos_q = '0;
      end
   endtask

   // builds one node; nbytes is the number of bytes actually sent
   task automatic push_node(input logic [1:0] func, input logic [16:0] nb,
                            input logic [15:0] magic, input logic [15:0] cnt,
                            input logic [15:0] dep, input int nbytes);
      byte_txn_type t;
      logic [15:0] cap, len;
      logic [7:0] hdr[12];
      cap = 16'($urandom);
      hdr = '{magic[7:0], magic[15:8], cnt[7:0], cnt[15:8], cap[7:0], cap[15:8],
              dep[7:0], dep[15:8], 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom)};
      len = '0;
      for (int i = 0; i < nbytes; i++) begin
         if (i >= 12 && (i - 12) % 12 == 4) begin
            case ($urandom_range(5))
               0: len = UNWRITTEN_BASE;
               1: len = UNWRITTEN_BASE + 1'b1;
               2: len = 16'hFFFF;
               3: len = '0;
               default: len = 16'($urandom);
            endcase
         end
         t.data_byte = (i < 12) ? hdr[i] :
                       ((i - 12) % 12 == 4) ? len[7:0] :
                       ((i - 12) % 12 == 5) ? len[15:8] : 8'($urandom);
         t.func = (i == 0) ? func : 2'($urandom);
         t.node_bytes = (i == 0) ? nb : 17'($urandom);
         t.last_byte = (i == nbytes - 1);
         pending_bytes = {pending_bytes, t};
      end
   endtask

   task automatic random_node();
      logic [1:0] func;
      logic [15:0] cnt, dep, magic;
      logic [16:0] nb;
      int nbytes;
      func = 2'($urandom_range(3));
      cnt = 16'($urandom_range(4));
      dep = (func == MODE_INDEX) ? 16'($urandom_range(1, 6)) :
            (func == MODE_LEAF) ? 16'd0 : 16'($urandom_range(3));
      magic = NODE_MAGIC;
      nb = 17'(12 + 12 * cnt + $urandom_range(3));
      nbytes = int'(nb);
      if ($urandom_range(99) < 8) nbytes = nbytes + $urandom_range(1, 6);
      if ($urandom_range(99) < 25) begin
         case ($urandom_range(4))
            0: magic = 16'($urandom);
            1: dep = 16'($urandom);
            2: nb = 17'($urandom_range(0, 23));
            3: nbytes = $urandom_range(1, nbytes);
            default: nb = 17'($urandom);
         endcase
      end
      push_node(func, nb, magic, cnt, dep, nbytes);
   endtask

   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_depth_limit(input logic [15:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      depth_limit = v;
   endtask

   task automatic random_bytes(input int count);
      int start;
      start = pending_bytes.size();
      while (pending_bytes.size() - start < count) random_node();
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
            byte_txn_type t;
            t = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= t.data_byte;
            req_func <= t.func;
            req_node_bytes <= t.node_bytes;
            req_last_byte <= t.last_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver ready
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      if (reset) begin
         pos_q = '0; mode_q = '0; size_q = '0; hdr_entries_q = '0;
         entries_seen_q = '0; finished_q = 1'b0;
         depth_limit = MAX_DEPTH_RST;
         for (int i = 0; i < 12; i++) ent_buf[i] = '0;
      end else begin
         if (req_valid && req_ready) begin
            byte_txn_type t;
            bit got;
            node_result_type r;
            t = '{req_data_byte, req_func, req_node_bytes, req_last_byte};
            parse_byte(t, got, r);
            if (got) expected_results = {expected_results, r};
         end
         if (rsp_valid && rsp_ready) begin
            node_result_type e;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result transaction, expected none, actual kind %0d",
                        $time, rsp_kind);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               check_field("kind", e.kind, rsp_kind);
               check_field("error_code", e.error_code, rsp_error_code);
               check_field("entry_count", e.entry_count, rsp_entry_count);
               check_field("entry_capacity", e.entry_capacity, rsp_entry_capacity);
               check_field("tree_depth", e.tree_depth, rsp_tree_depth);
               check_field("file_block", e.file_block, rsp_file_block);
               check_field("block_count", e.block_count, rsp_block_count);
               check_field("device_block", e.device_block, rsp_device_block);
               check_field("written", e.written, rsp_written);
               check_field("last_result", e.last_result, rsp_last_result);
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed
      push_node(MODE_HDR, 17'd12, 16'h1234, 16'd0, 16'd0, 12);
      push_node(MODE_HDR, 17'd12, NODE_MAGIC, 16'd0, 16'd6, 12);
      push_node(MODE_HDR, 17'd23, NODE_MAGIC, 16'd1, 16'd0, 23);
      push_node(MODE_LEAF, 17'd5, NODE_MAGIC, 16'd0, 16'd0, 12);
      push_node(MODE_LEAF, 17'd48, NODE_MAGIC, 16'd3, 16'd2, 48);
      push_node(MODE_INDEX, 17'd48, NODE_MAGIC, 16'd3, 16'd0, 48);
      push_node(MODE_HDR, 17'd40, NODE_MAGIC, 16'd2, 16'd5, 20);
      push_node(MODE_RSVD, 17'd60, NODE_MAGIC, 16'd4, 16'd1, 30);
      push_node(MODE_LEAF, 17'h1FFFF, NODE_MAGIC, 16'd4, 16'd0, 60);
      push_node(MODE_INDEX, 17'd36, NODE_MAGIC, 16'd2, 16'd5, 36);
      push_node(MODE_LEAF, 17'd36, NODE_MAGIC, 16'd2, 16'd0, 24);
      push_node(MODE_LEAF, 17'd36, NODE_MAGIC, 16'd2, 16'd0, 30);
      push_node(MODE_INDEX, 17'd24, NODE_MAGIC, 16'd1, 16'd3, 7);
      push_node(MODE_LEAF, 17'd65536, NODE_MAGIC, 16'd5460, 16'd0, 40);
      push_node(MODE_LEAF, 17'd0, NODE_MAGIC, 16'd0, 16'd0, 12);
      random_bytes(65);
      stall_left = 200;
      wait_idle();

      write_depth_limit(16'hFFFF);
      push_node(MODE_INDEX, 17'd24, NODE_MAGIC, 16'd1, 16'hFFFF, 24);
      random_bytes(65);
      wait_idle();

      write_depth_limit(16'd0);
      @(negedge clock);
      send_idle = 52;
      recv_idle = 19;
      random_bytes(65);
      wait_idle();

      write_depth_limit(16'($urandom));
      random_bytes(65);
      @(negedge clock);
      stall_left = 150;
      wait_idle();

      write_depth_limit(16'd3);
      @(negedge clock);
      send_idle = 0;
      recv_idle = 0;
      random_bytes(65);
      wait_idle();

      write_depth_limit(MAX_DEPTH_RST);
      random_bytes(65);
      wait_idle();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/enp_pkg.sv
rtl/core/enp_front.sv
rtl/core/enp_queue.sv
rtl/core/enp_back.sv
rtl/core/extent_node_parser.sv
verif/tb.sv
